@@ sv/space_vector_pwm_duty_macros.svh @@
// Assertion macros for the space vector PWM duty block.
// Depends on nothing; taken in by the files that assert.
`ifndef SPACE_VECTOR_PWM_DUTY_MACROS_SVH
`define SPACE_VECTOR_PWM_DUTY_MACROS_SVH

// implication checked in the same cycle
`define SVPD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked after the delay given by lat
`define SVPD_ASSERT_LAT(label, clk, rst_n, ante, lat, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(lat) (cons)) \
    else $error(msg);

`endif

@@ sv/svpd_pkg.sv @@
// Shared types and constants of the space vector PWM duty block.
// Depends on nothing.
package svpd_pkg;

  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned IN_W       = 16;
  localparam int unsigned DUTY_W     = 14;
  localparam logic [GAIN_W-1:0] RESET_GAIN = 24'd945950;
  localparam int unsigned FULL_Q8    = 25600;
  localparam int unsigned HALF_Q8    = 12800;
  localparam int unsigned HALF_SQRT3 = 56756;
  localparam int unsigned PROJ_W     = 34;
  localparam int unsigned PROD_W     = PROJ_W + GAIN_W + 1;
  localparam int unsigned UR_W       = 26;
  localparam int unsigned T_W        = 25;
  localparam int unsigned SUM_W      = 26;
  localparam int unsigned NUM_W      = T_W + 15;
  localparam int unsigned QUOT_W     = 15;
  localparam int unsigned LATENCY    = 7 + QUOT_W;

  typedef enum logic [2:0] {
    SEC_0,
    SEC_1,
    SEC_2,
    SEC_3,
    SEC_4,
    SEC_5
  } sector_e;

  typedef struct packed {
    logic signed [IN_W-1:0] volt_alpha;
    logic signed [IN_W-1:0] volt_beta;
  } svpd_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [DUTY_W-1:0] duty_c;
    logic              overmodulated;
  } svpd_out_t;

  typedef struct packed {
    logic    valid;
    sector_e sector;
    logic    over;
  } svpd_ctl_t;

endpackage

@@ sv/svpd_proj.sv @@
// Projection stages: three axis projections, gain multiply, round to Q.8.
// Depends on svpd_pkg.
module svpd_proj (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  svpd_pkg::svpd_in_t                     word_i,
  input  logic [svpd_pkg::GAIN_W-1:0]            gain_i,
  output logic                                   valid_o,
  output logic signed [svpd_pkg::UR_W-1:0]       ur1_o,
  output logic signed [svpd_pkg::UR_W-1:0]       ur2_o,
  output logic signed [svpd_pkg::UR_W-1:0]       ur3_o
);

  localparam int unsigned PROJ_W = svpd_pkg::PROJ_W;
  localparam int unsigned PROD_W = svpd_pkg::PROD_W;
  localparam int unsigned UR_W   = svpd_pkg::UR_W;
  localparam int unsigned GAIN_W_S = svpd_pkg::GAIN_W;

  function automatic logic signed [UR_W-1:0] to_q8(input logic signed [PROD_W-1:0] x);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] rnd;
    logic [UR_W-1:0]   r;
    mag = x[PROD_W-1] ? PROD_W'(-x) : PROD_W'(x);
    rnd = mag + {{(PROD_W-32){1'b0}}, 1'b1, 31'b0};
    r   = rnd[32 +: UR_W];
    return x[PROD_W-1] ? UR_W'(-r) : r;
  endfunction

  logic signed [32:0]       a_mul;
  logic signed [PROJ_W-1:0] a_ext, b_ext, b_half;
  logic signed [PROJ_W-1:0] p1_d, p2_d, p3_d;
  logic signed [PROJ_W-1:0] p1_q, p2_q, p3_q;
  logic signed [PROD_W-1:0] m1_q, m2_q, m3_q;
  logic signed [UR_W-1:0]   ur1_q, ur2_q, ur3_q;
  logic                     v1_q, v2_q, v3_q;
  logic signed [GAIN_W_S:0] gain_s;

  always_comb begin
    a_mul  = word_i.volt_alpha * $signed(17'(svpd_pkg::HALF_SQRT3));
    a_ext  = PROJ_W'(a_mul);
    b_ext  = PROJ_W'(word_i.volt_beta);
    b_half = b_ext <<< 15;
    p1_d   = b_ext <<< 16;
    p2_d   = a_ext - b_half;
    p3_d   = -b_half - a_ext;
  end

  assign gain_s = $signed({1'b0, gain_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q  <= p1_d;
    p2_q  <= p2_d;
    p3_q  <= p3_d;
    m1_q  <= p1_q * gain_s;
    m2_q  <= p2_q * gain_s;
    m3_q  <= p3_q * gain_s;
    ur1_q <= to_q8(m1_q);
    ur2_q <= to_q8(m2_q);
    ur3_q <= to_q8(m3_q);
  end

  assign valid_o = v3_q;
  assign ur1_o   = ur1_q;
  assign ur2_o   = ur2_q;
  assign ur3_o   = ur3_q;

endmodule

@@ sv/svpd_sector.sv @@
// Sector stages: sector pick, active times, their sum and scaled numerators.
// Depends on svpd_pkg.
module svpd_sector (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  logic signed [svpd_pkg::UR_W-1:0]       ur1_i,
  input  logic signed [svpd_pkg::UR_W-1:0]       ur2_i,
  input  logic signed [svpd_pkg::UR_W-1:0]       ur3_i,
  output svpd_pkg::svpd_ctl_t                    ctl_o,
  output logic [svpd_pkg::T_W-1:0]               t1_o,
  output logic [svpd_pkg::T_W-1:0]               t2_o,
  output logic [svpd_pkg::SUM_W-1:0]             sum_o,
  output logic [svpd_pkg::NUM_W-1:0]             n1_o,
  output logic [svpd_pkg::NUM_W-1:0]             n2_o
);

  localparam int unsigned T_W   = svpd_pkg::T_W;
  localparam int unsigned SUM_W = svpd_pkg::SUM_W;
  localparam int unsigned NUM_W = svpd_pkg::NUM_W;
  localparam int unsigned UR_W  = svpd_pkg::UR_W;

  logic               pos1, pos2, pos3;
  logic [T_W-1:0]     t1_d, t2_d, t1_q, t2_q, t1b_q, t2b_q;
  logic [SUM_W-1:0]   sum_d, sum_q, sumb_q;
  svpd_pkg::sector_e  sec_d;
  svpd_pkg::svpd_ctl_t ctl_q, ctlb_q;
  logic [NUM_W-1:0]   n1_q, n2_q;

  assign pos1 = !ur1_i[UR_W-1] && (ur1_i != '0);
  assign pos2 = !ur2_i[UR_W-1] && (ur2_i != '0);
  assign pos3 = !ur3_i[UR_W-1] && (ur3_i != '0);

  always_comb begin
    if (pos1) begin
      if (pos2) begin
        t1_d = T_W'(ur2_i);  t2_d = T_W'(ur1_i);  sec_d = svpd_pkg::SEC_0;
      end else if (pos3) begin
        t1_d = T_W'(ur1_i);  t2_d = T_W'(ur3_i);  sec_d = svpd_pkg::SEC_1;
      end else begin
        t1_d = T_W'(-ur2_i); t2_d = T_W'(-ur3_i); sec_d = svpd_pkg::SEC_2;
      end
    end else begin
      if (pos2) begin
        if (pos3) begin
          t1_d = T_W'(ur3_i);  t2_d = T_W'(ur2_i);  sec_d = svpd_pkg::SEC_3;
        end else begin
          t1_d = T_W'(-ur3_i); t2_d = T_W'(-ur1_i); sec_d = svpd_pkg::SEC_4;
        end
      end else begin
        t1_d = T_W'(-ur1_i); t2_d = T_W'(-ur2_i); sec_d = svpd_pkg::SEC_5;
      end
    end
    sum_d = SUM_W'(t1_d) + SUM_W'(t2_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q  <= '0;
      ctlb_q <= '0;
    end else begin
      ctl_q.valid  <= valid_i;
      ctl_q.sector <= sec_d;
      ctl_q.over   <= sum_d > SUM_W'(svpd_pkg::FULL_Q8);
      ctlb_q       <= ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q   <= t1_d;
    t2_q   <= t2_d;
    sum_q  <= sum_d;
    t1b_q  <= t1_q;
    t2b_q  <= t2_q;
    sumb_q <= sum_q;
    n1_q   <= NUM_W'(t1_q) * NUM_W'(svpd_pkg::FULL_Q8);
    n2_q   <= NUM_W'(t2_q) * NUM_W'(svpd_pkg::FULL_Q8);
  end

  assign ctl_o = ctlb_q;
  assign t1_o  = t1b_q;
  assign t2_o  = t2b_q;
  assign sum_o = sumb_q;
  assign n1_o  = n1_q;
  assign n2_o  = n2_q;

endmodule

@@ sv/svpd_div.sv @@
// Restoring divider pipeline, one quotient bit per stage, two lanes.
// Depends on svpd_pkg.
module svpd_div (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  svpd_pkg::svpd_ctl_t                    ctl_i,
  input  logic [svpd_pkg::T_W-1:0]               t1_i,
  input  logic [svpd_pkg::T_W-1:0]               t2_i,
  input  logic [svpd_pkg::SUM_W-1:0]             sum_i,
  input  logic [svpd_pkg::NUM_W-1:0]             n1_i,
  input  logic [svpd_pkg::NUM_W-1:0]             n2_i,
  output svpd_pkg::svpd_ctl_t                    ctl_o,
  output logic [svpd_pkg::QUOT_W-1:0]            t1_o,
  output logic [svpd_pkg::QUOT_W-1:0]            t2_o
);

  localparam int unsigned QUOT_W = svpd_pkg::QUOT_W;
  localparam int unsigned NUM_W  = svpd_pkg::NUM_W;
  localparam int unsigned SUM_W  = svpd_pkg::SUM_W;

  svpd_pkg::svpd_ctl_t ctl_q  [QUOT_W];
  logic [QUOT_W-1:0]   t1_q   [QUOT_W];
  logic [QUOT_W-1:0]   t2_q   [QUOT_W];
  logic [SUM_W-1:0]    sum_q  [QUOT_W];
  logic [NUM_W-1:0]    rem1_q [QUOT_W];
  logic [NUM_W-1:0]    rem2_q [QUOT_W];
  logic [QUOT_W-1:0]   q1_q   [QUOT_W];
  logic [QUOT_W-1:0]   q2_q   [QUOT_W];

  for (genvar g = 0; g < QUOT_W; g++) begin : g_stage
    localparam int unsigned BIT = QUOT_W - 1 - g;
    svpd_pkg::svpd_ctl_t ctl_in;
    logic [QUOT_W-1:0]   t1_in, t2_in, q1_in, q2_in;
    logic [SUM_W-1:0]    sum_in;
    logic [NUM_W-1:0]    r1_in, r2_in;
    logic [NUM_W:0]      dv, diff1, diff2;
    logic                ge1, ge2;

    if (g == 0) begin : g_first
      assign ctl_in = ctl_i;
      assign t1_in  = QUOT_W'(t1_i);
      assign t2_in  = QUOT_W'(t2_i);
      assign sum_in = sum_i;
      assign r1_in  = n1_i;
      assign r2_in  = n2_i;
      assign q1_in  = '0;
      assign q2_in  = '0;
    end else begin : g_next
      assign ctl_in = ctl_q[g-1];
      assign t1_in  = t1_q[g-1];
      assign t2_in  = t2_q[g-1];
      assign sum_in = sum_q[g-1];
      assign r1_in  = rem1_q[g-1];
      assign r2_in  = rem2_q[g-1];
      assign q1_in  = q1_q[g-1];
      assign q2_in  = q2_q[g-1];
    end

    assign dv    = (NUM_W+1)'(sum_in) << BIT;
    assign diff1 = {1'b0, r1_in} - dv;
    assign diff2 = {1'b0, r2_in} - dv;
    assign ge1   = {1'b0, r1_in} >= dv;
    assign ge2   = {1'b0, r2_in} >= dv;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[g] <= '0;
      end else begin
        ctl_q[g] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      t1_q[g]   <= t1_in;
      t2_q[g]   <= t2_in;
      sum_q[g]  <= sum_in;
      rem1_q[g] <= ge1 ? NUM_W'(diff1) : r1_in;
      rem2_q[g] <= ge2 ? NUM_W'(diff2) : r2_in;
      q1_q[g]   <= q1_in | (ge1 ? (QUOT_W'(1) << BIT) : '0);
      q2_q[g]   <= q2_in | (ge2 ? (QUOT_W'(1) << BIT) : '0);
    end
  end

  assign ctl_o = ctl_q[QUOT_W-1];
  assign t1_o  = ctl_q[QUOT_W-1].over ? q1_q[QUOT_W-1] : t1_q[QUOT_W-1];
  assign t2_o  = ctl_q[QUOT_W-1].over ? q2_q[QUOT_W-1] : t2_q[QUOT_W-1];

endmodule

@@ sv/svpd_out.sv @@
// Output stage: quarter-period times, per-sector phase routing, result register.
// Depends on svpd_pkg.
module svpd_out (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  svpd_pkg::svpd_ctl_t                    ctl_i,
  input  logic [svpd_pkg::QUOT_W-1:0]            t1_i,
  input  logic [svpd_pkg::QUOT_W-1:0]            t2_i,
  output logic                                   strobe_o,
  output svpd_pkg::svpd_out_t                    word_o
);

  localparam int unsigned DUTY_W = svpd_pkg::DUTY_W;
  localparam logic [16:0] FULL17 = 17'(svpd_pkg::FULL_Q8);

  logic [16:0]         sa, sb, sc;
  logic [DUTY_W-1:0]   ta, tb, tc;
  svpd_pkg::svpd_out_t word_d, word_q;
  logic                strobe_q;

  always_comb begin
    sa = FULL17 - {2'b0, t1_i} - {2'b0, t2_i} + 17'd2;
    sb = FULL17 + {2'b0, t1_i} - {2'b0, t2_i} + 17'd2;
    sc = FULL17 + {2'b0, t1_i} + {2'b0, t2_i} + 17'd2;
    ta = sa[2 +: DUTY_W];
    tb = sb[2 +: DUTY_W];
    tc = sc[2 +: DUTY_W];
    word_d.overmodulated = ctl_i.over;
    unique case (ctl_i.sector)
      svpd_pkg::SEC_0: begin
        word_d.duty_a = ta; word_d.duty_b = tb; word_d.duty_c = tc;
      end
      svpd_pkg::SEC_1: begin
        word_d.duty_a = tc; word_d.duty_b = ta; word_d.duty_c = tb;
      end
      svpd_pkg::SEC_2: begin
        word_d.duty_a = tb; word_d.duty_b = ta; word_d.duty_c = tc;
      end
      svpd_pkg::SEC_3: begin
        word_d.duty_a = tb; word_d.duty_b = tc; word_d.duty_c = ta;
      end
      svpd_pkg::SEC_4: begin
        word_d.duty_a = ta; word_d.duty_b = tc; word_d.duty_c = tb;
      end
      default: begin
        word_d.duty_a = tc; word_d.duty_b = tb; word_d.duty_c = ta;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign strobe_o = strobe_q;
  assign word_o   = word_q;

endmodule

@@ sv/space_vector_pwm_duty.sv @@
// Top level of the space vector PWM duty block: gain register and pipeline.
// Depends on svpd_pkg, svpd_proj, svpd_sector, svpd_div, svpd_out and the macro header.
//
//   channel   signals                               direction
//   input     start, busy, in_word_i                in; busy out
//   config    cfg_valid_i, cfg_ready_o, cfg_data_i  in; cfg_ready_o out
//   result    out_strobe_o, out_word_o              out
//
// One word enters per cycle; the result strobes after passing through
// the 15-stage restoring divider plus seven arithmetic and register stages.
// busy stays low and cfg_ready_o stays high; the receiver cannot stall.
// Reset clears all valid bits and loads gain_q with 945950.
`include "space_vector_pwm_duty_macros.svh"

module space_vector_pwm_duty (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  svpd_pkg::svpd_in_t                in_word_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [svpd_pkg::GAIN_W-1:0]       cfg_data_i,
  output logic                              out_strobe_o,
  output svpd_pkg::svpd_out_t               out_word_o
);

  localparam int unsigned UR_W = svpd_pkg::UR_W;

  logic [svpd_pkg::GAIN_W-1:0]    gain_q;
  logic                           in_valid_q;
  svpd_pkg::svpd_in_t             in_word_q;
  logic                           ur_valid;
  logic signed [UR_W-1:0]         ur1, ur2, ur3;
  svpd_pkg::svpd_ctl_t            sec_ctl, div_ctl;
  logic [svpd_pkg::T_W-1:0]       t1, t2;
  logic [svpd_pkg::SUM_W-1:0]     sum;
  logic [svpd_pkg::NUM_W-1:0]     n1, n2;
  logic [svpd_pkg::QUOT_W-1:0]    f1, f2;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q     <= svpd_pkg::RESET_GAIN;
      in_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        gain_q <= cfg_data_i;
      end
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    in_word_q <= in_word_i;
  end

  svpd_proj u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .word_i  (in_word_q),
    .gain_i  (gain_q),
    .valid_o (ur_valid),
    .ur1_o   (ur1),
    .ur2_o   (ur2),
    .ur3_o   (ur3)
  );

  svpd_sector u_sector (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ur_valid),
    .ur1_i   (ur1),
    .ur2_i   (ur2),
    .ur3_i   (ur3),
    .ctl_o   (sec_ctl),
    .t1_o    (t1),
    .t2_o    (t2),
    .sum_o   (sum),
    .n1_o    (n1),
    .n2_o    (n2)
  );

  svpd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sec_ctl),
    .t1_i   (t1),
    .t2_i   (t2),
    .sum_i  (sum),
    .n1_i   (n1),
    .n2_i   (n2),
    .ctl_o  (div_ctl),
    .t1_o   (f1),
    .t2_o   (f2)
  );

  svpd_out u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (div_ctl),
    .t1_i     (f1),
    .t2_i     (f2),
    .strobe_o (out_strobe_o),
    .word_o   (out_word_o)
  );

  `SVPD_ASSERT_LAT(a_word_out, clk_i, rst_ni, start && !busy, svpd_pkg::LATENCY, out_strobe_o, "accepted word produced no result")
  `SVPD_ASSERT_IMP(a_no_phantom, clk_i, rst_ni, out_strobe_o, $past(start && !busy, svpd_pkg::LATENCY), "result without accepted word")
  `SVPD_ASSERT_IMP(a_duty_range, clk_i, rst_ni, out_strobe_o, (out_word_o.duty_a <= 14'(svpd_pkg::HALF_Q8)) && (out_word_o.duty_b <= 14'(svpd_pkg::HALF_Q8)) && (out_word_o.duty_c <= 14'(svpd_pkg::HALF_Q8)), "duty out of range")

endmodule

@@ verif/tb_space_vector_pwm_duty.sv @@
// Testbench for space_vector_pwm_duty: drives alpha/beta command words and gain writes,
// predicts the phase duty words in fixed point and checks every strobed result.
// Depends on svpd_pkg and the space_vector_pwm_duty RTL.
`timescale 1ns / 1ps

module tb_space_vector_pwm_duty;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  svpd_pkg::svpd_in_t            in_word_i = '0;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [svpd_pkg::GAIN_W-1:0]   cfg_data_i = '0;
  logic                          out_strobe_o;
  svpd_pkg::svpd_out_t           out_word_o;

  space_vector_pwm_duty dut (
    .clk_i, .rst_ni, .start, .busy, .in_word_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i, .out_strobe_o, .out_word_o
  );

  always #5 clk_i = ~clk_i;

  logic [svpd_pkg::GAIN_W-1:0] gain_model;
  svpd_pkg::svpd_in_t          cmd_queue[$];
  int unsigned                 gap_queue[$];
  svpd_pkg::svpd_out_t         duty_expected[$];
  int unsigned       n_mismatch = 0;
  int unsigned       n_checked = 0;
  int unsigned       n_over = 0;
  int unsigned       n_sent = 0;
  int unsigned       gap_left = 0;
  logic              driving = 1'b0;

  function automatic longint round_q8(longint x);
    if (x >= 0) begin
      return (x + 64'sh8000_0000) >>> 32;
    end
    return -((-x + 64'sh8000_0000) >>> 32);
  endfunction

  function automatic svpd_pkg::svpd_out_t svpwm_duty(svpd_pkg::svpd_in_t w,
                                                     logic [svpd_pkg::GAIN_W-1:0] g);
    longint a, b, k, ur1, ur2, ur3, t1, t2, s, ta, tb, tc;
    logic [svpd_pkg::DUTY_W-1:0] da, db, dc;
    svpd_pkg::sector_e sec;
    svpd_pkg::svpd_out_t r;
    a = longint'(w.volt_alpha);
    b = longint'(w.volt_beta);
    k = longint'({40'd0, g});
    ur1 = round_q8(k * (b * 65536));
    ur2 = round_q8(k * (a * svpd_pkg::HALF_SQRT3 - b * 32768));
    ur3 = round_q8(k * (-b * 32768 - a * svpd_pkg::HALF_SQRT3));
    if (ur1 > 0) begin
      if (ur2 > 0) begin
        t1 = ur2; t2 = ur1; sec = svpd_pkg::SEC_0;
      end else if (ur3 > 0) begin
        t1 = ur1; t2 = ur3; sec = svpd_pkg::SEC_1;
      end else begin
        t1 = -ur2; t2 = -ur3; sec = svpd_pkg::SEC_2;
      end
    end else if (ur2 > 0) begin
      if (ur3 > 0) begin
        t1 = ur3; t2 = ur2; sec = svpd_pkg::SEC_3;
      end else begin
        t1 = -ur3; t2 = -ur1; sec = svpd_pkg::SEC_4;
      end
    end else begin
      t1 = -ur1; t2 = -ur2; sec = svpd_pkg::SEC_5;
    end
    s = t1 + t2;
    r.overmodulated = (s > svpd_pkg::FULL_Q8);
    if (r.overmodulated) begin
      t1 = (t1 * svpd_pkg::FULL_Q8) / s;
      t2 = (t2 * svpd_pkg::FULL_Q8) / s;
    end
    ta = (svpd_pkg::FULL_Q8 - t1 - t2 + 2) / 4;
    tb = (svpd_pkg::FULL_Q8 + t1 - t2 + 2) / 4;
    tc = (svpd_pkg::FULL_Q8 + t1 + t2 + 2) / 4;
    da = svpd_pkg::DUTY_W'(ta);
    db = svpd_pkg::DUTY_W'(tb);
    dc = svpd_pkg::DUTY_W'(tc);
    case (sec)
      svpd_pkg::SEC_0: begin r.duty_a = da; r.duty_b = db; r.duty_c = dc; end
      svpd_pkg::SEC_1: begin r.duty_a = dc; r.duty_b = da; r.duty_c = db; end
      svpd_pkg::SEC_2: begin r.duty_a = db; r.duty_b = da; r.duty_c = dc; end
      svpd_pkg::SEC_3: begin r.duty_a = db; r.duty_b = dc; r.duty_c = da; end
      svpd_pkg::SEC_4: begin r.duty_a = da; r.duty_b = dc; r.duty_c = db; end
      default: begin r.duty_a = dc; r.duty_b = db; r.duty_c = da; end
    endcase
    return r;
  endfunction

  // driver: words change on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && driving) begin
      if (start && !busy) begin
        duty_expected.push_back(svpwm_duty(in_word_i, gain_model));
        n_sent <= n_sent + 1;
      end
      if (start && busy) begin
      end else if (gap_left != 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (cmd_queue.size() != 0) begin
        in_word_i <= cmd_queue.pop_front();
        gap_left <= gap_queue.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_strobe_o) begin
      if (duty_expected.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %p", out_word_o);
      end else begin
        svpd_pkg::svpd_out_t e;
        e = duty_expected.pop_front();
        n_checked++;
        if (e.overmodulated) n_over++;
        if (out_word_o !== e) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("mismatch: expected %p, got %p", e, out_word_o);
        end
      end
    end
  end

  task automatic add_cmd(int alpha, int beta, bit burst);
    svpd_pkg::svpd_in_t w;
    w.volt_alpha = alpha[15:0];
    w.volt_beta = beta[15:0];
    cmd_queue.push_back(w);
    gap_queue.push_back((burst || $urandom_range(3) == 0) ? 0 : $urandom_range(15));
  endtask

  task automatic write_gain(logic [svpd_pkg::GAIN_W-1:0] g);
    @(negedge clk_i);
    cfg_data_i <= g;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    gain_model = g;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase();
    @(negedge clk_i);
    driving = 1'b1;
    while (cmd_queue.size() != 0 || gap_left != 0 || start) @(posedge clk_i);
    while (duty_expected.size() != 0) @(posedge clk_i);
    repeat (svpd_pkg::LATENCY + 5) @(posedge clk_i);
    driving = 1'b0;
  endtask

  initial begin
    logic [svpd_pkg::GAIN_W-1:0] gains[6];
    int edge_v[6];
    gains = '{svpd_pkg::RESET_GAIN, 24'hFFFFFF, 24'd0, 24'd1, 24'd60000, 24'd945950};
    edge_v = '{-32768, 32767, 0, 1, -1, 256};
    gain_model = svpd_pkg::RESET_GAIN;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: reset gain, edge values on each axis, then corner and mixed words
    foreach (edge_v[i]) begin
      add_cmd(edge_v[i], 0, 0);
      add_cmd(0, edge_v[i], 0);
    end
    add_cmd(-32768, -32768, 0);
    add_cmd(32767, 32767, 0);
    add_cmd(32767, -32768, 0);
    add_cmd(-32768, 32767, 0);
    for (int s = 0; s < 6; s++) add_cmd(s * 1000 - 2500, (s % 3 - 1) * 1500, 0);
    run_phase();
    for (int p = 0; p < 6; p++) begin
      write_gain(p == 5 ? 24'($urandom) : gains[p]);
      for (int i = 0; i < 125; i++) begin
        int r;
        r = $urandom_range(9);
        if (r < 2) add_cmd($urandom_range(65535) - 32768, $urandom_range(65535) - 32768, p == 2);
        else if (r < 4) add_cmd($urandom_range(511) - 256, $urandom_range(511) - 256, p == 2);
        else add_cmd($urandom_range(8191) - 4096, $urandom_range(8191) - 4096, p == 2);
      end
      run_phase();
    end
    $display("checked %0d duty words over 7 gain settings, %0d overmodulated",
             n_checked, n_over);
    if (n_mismatch == 0 && duty_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end
endmodule
